// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and constants of the periodic task tick scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

   // table size and per-tick report limit
   localparam int PTS_MAX_TASKS   = 8;
   localparam int PTS_MAX_RESULTS = 8;
   localparam int PTS_RES_W       = 4;

   // configuration port
   localparam int             PTS_CSR_ADDR_W      = 3;
   localparam int             PTS_CSR_DATA_W      = 32;
   localparam int             PTS_STEP_W          = 16;
   localparam logic [0:0]     PTS_REG_TICK_STEP   = 1'b0;
   localparam logic [15:0]    PTS_TICK_STEP_RESET = 16'd1;

   // input function codes
   localparam logic PTS_FUNC_TICK = 1'b0;
   localparam logic PTS_FUNC_ADD  = 1'b1;

   // result kind codes
   localparam logic PTS_KIND_ACK  = 1'b0;
   localparam logic PTS_KIND_TICK = 1'b1;

   // table word: period in the upper half, elapsed time in the lower half
   localparam int PTS_WORD_W = 64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACK,
      ST_CALC,
      ST_FLUSH
   } pts_state_type;

   // one result loaded into the output register
   typedef struct packed {
      logic       load;
      logic       kind;
      logic       accepted;
      logic       fired;
      logic [2:0] task_index;
      logic       last;
   } pts_rsp_type;

endpackage

// ===== rtl/pts_ram.sv =====
// ----------------------------------------------------------------------------
// pts_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pts_ram #(
   parameter  int WIDTH  = 64,
   parameter  int DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pts_alu.sv =====
// ----------------------------------------------------------------------------
// pts_alu
// shared due check and saturating elapsed-time update for one task
// ----------------------------------------------------------------------------
module pts_alu
   import pts_pkg::*;
(
   input  logic [31:0]           period_i,
   input  logic [31:0]           elapsed_i,
   input  logic [PTS_STEP_W-1:0] step_i,
   output logic                  fire_o,
   output logic [31:0]           elapsed_o
);

   logic [31:0] base;
   logic [32:0] sum;

   always_comb begin
      fire_o    = (elapsed_i >= period_i);
      base      = fire_o ? 32'd0 : elapsed_i;
      sum       = {1'b0, base} + {17'd0, step_i};
      // saturate at the all-ones value
      elapsed_o = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   end

endmodule

// ===== rtl/pts_seq.sv =====
// ----------------------------------------------------------------------------
// pts_seq
// sequencer: task table walk, add handling and result ordering
// ----------------------------------------------------------------------------
module pts_seq
   import pts_pkg::*;
#(
   parameter  int MAX_TASKS = PTS_MAX_TASKS,
   localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
   localparam int CNT_W     = $clog2(MAX_TASKS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid_i,
   input  logic                  req_func_i,
   input  logic [31:0]           req_period_i,
   input  logic [31:0]           req_elapsed_i,
   output logic                  req_ready_o,
   input  logic                  out_free_i,
   output logic                  rd_en_o,
   output logic [IDX_W-1:0]      rd_addr_o,
   input  logic [PTS_WORD_W-1:0] rd_data_i,
   output logic                  wr_en_o,
   output logic [IDX_W-1:0]      wr_addr_o,
   output logic [PTS_WORD_W-1:0] wr_data_o,
   input  logic                  fire_i,
   input  logic [31:0]           new_elapsed_i,
   output pts_rsp_type           rsp_o
);

   pts_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [PTS_RES_W-1:0] n_ff, n_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [2:0]           pend_idx_ff, pend_idx_in;
   logic                 ack_ok_ff, ack_ok_in;
   logic [2:0]           ack_slot_ff, ack_slot_in;

   logic                 accept;
   logic                 is_add;
   logic                 full;
   logic                 last_slot;
   logic                 report;
   logic                 stall;
   logic [IDX_W-1:0]     slot;
   logic [IDX_W+2:0]     idx_wide;
   logic [IDX_W+2:0]     slot_wide;

   always_comb begin
      accept    = req_valid_i && (state_ff == ST_IDLE);
      is_add    = (req_func_i == PTS_FUNC_ADD);
      full      = (count_ff == CNT_W'(MAX_TASKS));
      last_slot = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
      report    = fire_i && (n_ff < PTS_RES_W'(PTS_MAX_RESULTS));
      // a second due task needs the output register for the held one
      stall     = report && pend_valid_ff && !out_free_i;
      slot      = count_ff[IDX_W-1:0];
      idx_wide  = {3'b000, idx_ff};
      slot_wide = {3'b000, slot};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_add) begin
                  state_in = ST_ACK;
               end else if (count_ff == '0) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_ACK: begin
            if (out_free_i) state_in = ST_IDLE;
         end
         ST_CALC: begin
            if (!stall && last_slot) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (out_free_i) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready_o = (state_ff == ST_IDLE);
      rd_en_o     = 1'b0;
      rd_addr_o   = '0;
      wr_en_o     = 1'b0;
      wr_addr_o   = idx_ff;
      wr_data_o   = {rd_data_i[63:32], new_elapsed_i};
      rsp_o       = '0;
      case (state_ff)
         ST_IDLE: begin
            // slot zero is fetched ahead for a tick
            rd_en_o = 1'b1;
            if (accept && is_add && !full) begin
               wr_en_o   = 1'b1;
               wr_addr_o = slot;
               wr_data_o = {req_period_i, req_elapsed_i};
            end
         end
         ST_ACK: begin
            if (out_free_i) begin
               rsp_o.load       = 1'b1;
               rsp_o.kind       = PTS_KIND_ACK;
               rsp_o.accepted   = ack_ok_ff;
               rsp_o.task_index = ack_slot_ff;
               rsp_o.last       = 1'b1;
            end
         end
         ST_CALC: begin
            if (!stall) begin
               wr_en_o = 1'b1;
               if (!last_slot) begin
                  rd_en_o   = 1'b1;
                  rd_addr_o = idx_ff + IDX_W'(1);
               end
               if (report && pend_valid_ff) begin
                  rsp_o.load       = 1'b1;
                  rsp_o.kind       = PTS_KIND_TICK;
                  rsp_o.fired      = 1'b1;
                  rsp_o.task_index = pend_idx_ff;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free_i) begin
               rsp_o.load       = 1'b1;
               rsp_o.kind       = PTS_KIND_TICK;
               rsp_o.fired      = pend_valid_ff;
               rsp_o.task_index = pend_valid_ff ? pend_idx_ff : 3'd0;
               rsp_o.last       = 1'b1;
            end
         end
         default: begin
            req_ready_o = 1'b0;
         end
      endcase
   end

   // counters and held results
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      ack_ok_in     = ack_ok_ff;
      ack_slot_in   = ack_slot_ff;
      if (accept) begin
         idx_in        = '0;
         n_in          = '0;
         pend_valid_in = 1'b0;
         if (is_add) begin
            ack_ok_in   = !full;
            ack_slot_in = full ? 3'd0 : slot_wide[2:0];
            if (!full) count_in = count_ff + CNT_W'(1);
         end
      end
      if ((state_ff == ST_CALC) && !stall) begin
         if (report) begin
            pend_valid_in = 1'b1;
            pend_idx_in   = idx_wide[2:0];
            n_in          = n_ff + PTS_RES_W'(1);
         end
         if (!last_slot) idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_idx_ff <= pend_idx_in;
      ack_ok_ff   <= ack_ok_in;
      ack_slot_ff <= ack_slot_in;
   end

   // walk writes stay inside the stored slots
   a_wr_in_table: assert property (@(posedge clock) disable iff (reset)
      (wr_en_o && (state_ff == ST_CALC)) |-> (CNT_W'(wr_addr_o) < count_ff))
      else $error("table write beyond stored tasks");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TASKS))
      else $error("task count above table size");

   a_report_max: assert property (@(posedge clock) disable iff (reset)
      n_ff <= PTS_RES_W'(PTS_MAX_RESULTS))
      else $error("too many fired reports");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_o.load |-> out_free_i)
      else $error("result loaded over an untaken one");

   a_pend_counted: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (n_ff != '0))
      else $error("held fired task not counted");

endmodule

// ===== rtl/periodic_task_tick_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top
// periodic task table with tick walk, add requests and csr tick step
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata / data                          tuser   tlast
//  req_      in         [31:0] task_period [63:32] start_el.   func    -
//  rsp_      out        [0] accepted [1] fired [4:2] index     kind    last
//  csr_      apb        reg 0 at 0x0: tick_step_ms [15:0]      -       -
//
//  an add writes the table in its transfer cycle if a slot is free, then
//  ST_ACK loads the acknowledgement into the output register once it is free
//  a tick walks one table slot per cycle, unless stalled, through the
//  shared compare / saturating add unit, and ST_FLUSH loads the last result
//  a fired task is held one step so the last flag can go on the final one;
//  an untaken output register can stall the walk; req_tready is low throughout
//  synchronous active-high reset, no clearing pass: slots are only read once
//  written
//
module periodic_task_tick_scheduler_top
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = PTS_MAX_TASKS
) (
   input  logic                      clock,
   input  logic                      reset,
   // input stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [63:0]               req_tdata,   // task_period, start_elapsed
   input  logic                      req_tuser,   // func
   // result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // accepted, fired, task_index, pad
   output logic                      rsp_tuser,   // kind
   output logic                      rsp_tlast,
   // configuration port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [PTS_CSR_ADDR_W-1:0] csr_paddr,
   input  logic [PTS_CSR_DATA_W-1:0] csr_pwdata,
   output logic [PTS_CSR_DATA_W-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   // tick step register
   logic [PTS_STEP_W-1:0] tick_step_ff, tick_step_in;
   logic                  csr_hit;
   logic                  csr_wr;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_kind_ff, rsp_kind_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       out_free;

   // table and shared unit wiring
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [PTS_WORD_W-1:0] rd_data;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [PTS_WORD_W-1:0] wr_data;
   logic                  fire;
   logic [31:0]           new_elapsed;
   pts_rsp_type           rsp_load;

   // register 0 sits at byte address zero
   always_comb begin
      csr_pready   = 1'b1;
      csr_hit      = (csr_paddr[PTS_CSR_ADDR_W-1:2] == PTS_REG_TICK_STEP)
                     && (csr_paddr[1:0] == 2'b00);
      csr_wr       = csr_psel && csr_penable && csr_pwrite && csr_pready;
      tick_step_in = (csr_wr && csr_hit) ? csr_pwdata[PTS_STEP_W-1:0] : tick_step_ff;
      csr_prdata   = csr_hit ? {{(PTS_CSR_DATA_W-PTS_STEP_W){1'b0}}, tick_step_ff}
                             : '0;
   end

   // the output register frees up in the same cycle it is taken
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, rsp_load.task_index, rsp_load.fired, rsp_load.accepted};
         rsp_kind_in  = rsp_load.kind;
         rsp_last_in  = rsp_load.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_step_ff <= PTS_TICK_STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_step_ff <= tick_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // period and elapsed time of every slot
   pts_ram #(
      .WIDTH (PTS_WORD_W),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // one due check and saturating update per cycle while the walk is not stalled
   pts_alu u_alu (
      .period_i  (rd_data[63:32]),
      .elapsed_i (rd_data[31:0]),
      .step_i    (tick_step_ff),
      .fire_o    (fire),
      .elapsed_o (new_elapsed)
   );

   pts_seq #(
      .MAX_TASKS (MAX_TASKS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid_i   (req_tvalid),
      .req_func_i    (req_tuser),
      .req_period_i  (req_tdata[31:0]),
      .req_elapsed_i (req_tdata[63:32]),
      .req_ready_o   (req_tready),
      .out_free_i    (out_free),
      .rd_en_o       (rd_en),
      .rd_addr_o     (rd_addr),
      .rd_data_i     (rd_data),
      .wr_en_o       (wr_en),
      .wr_addr_o     (wr_addr),
      .wr_data_o     (wr_data),
      .fire_i        (fire),
      .new_elapsed_i (new_elapsed),
      .rsp_o         (rsp_load)
   );

endmodule
